// ===== rtl/srt_pkg.sv =====
// Shared types, constants and score helpers for the search result table.
`default_nettype none

package srt_pkg;

   localparam int INDEX_BITS = 12;
   localparam int TABLE_SIZE = 1 << INDEX_BITS;
   localparam int MATE_SCORE = 32000;
   localparam int PLY_LIMIT  = 128;
   localparam int MATE_RANGE = MATE_SCORE - 1000;
   localparam int SCORE_MAX = 32767;

   localparam logic [1:0] KIND_PROBE = 2'd0;
   localparam logic [1:0] KIND_STORE = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] BOUND_EXACT = 2'd0;
   localparam logic [1:0] BOUND_LOWER = 2'd1;
   localparam logic [1:0] BOUND_UPPER = 2'd2;

   localparam logic signed [17:0] SAT_HI  = 18'(SCORE_MAX);
   localparam logic signed [17:0] SAT_LO  = -18'(SCORE_MAX);
   localparam logic signed [17:0] MATE_HI = 18'(MATE_RANGE);
   localparam logic signed [17:0] MATE_LO = -18'(MATE_RANGE);
   localparam logic [6:0] PLY_MAX = 7'(PLY_LIMIT - 1);

   typedef struct packed {
      logic [1:0]         kind;
      logic [63:0]        hash;
      logic signed [7:0]  depth;
      logic [6:0]         ply;
      logic signed [15:0] score;
      logic signed [15:0] alpha;
      logic signed [15:0] beta;
      logic [1:0]         bound_type;
      logic               move_present;
      logic [15:0]        move_word;
   } req_type;

   typedef struct packed {
      logic               key_match;
      logic               usable_hit;
      logic               cutoff;
      logic signed [15:0] hit_score;
      logic signed [15:0] new_alpha;
      logic signed [15:0] new_beta;
      logic               move_found;
      logic [15:0]        found_move;
      logic               written;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [63:0]        key;
      logic signed [7:0]  depth;
      logic signed [15:0] score;
      logic [1:0]         bound;
      logic               has_move;
      logic [15:0]        move;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic sweep_wr;
      logic read;
      logic eval;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic req_clear;
      logic sweep_last;
      logic out_busy;
   } status_type;

   function automatic logic [6:0] clamp_ply(input logic [6:0] ply);
      if (ply > PLY_MAX) begin
         return PLY_MAX;
      end
      return ply;
   endfunction

   function automatic logic signed [15:0] sat_score(input logic signed [17:0] s);
      if (s > SAT_HI) begin
         return SAT_HI[15:0];
      end else if (s < SAT_LO) begin
         return SAT_LO[15:0];
      end
      return s[15:0];
   endfunction

   // Root-relative to node-relative: mate scores move away from zero by ply.
   function automatic logic signed [15:0] to_table(input logic signed [15:0] score,
                                                   input logic [6:0] ply);
      logic signed [17:0] s;
      logic signed [17:0] p;
      s = 18'(score);
      p = 18'(ply);
      if (s > MATE_HI) begin
         s = s + p;
      end else if (s < MATE_LO) begin
         s = s - p;
      end
      return sat_score(s);
   endfunction

   function automatic logic signed [15:0] from_table(input logic signed [15:0] score,
                                                     input logic [6:0] ply);
      logic signed [17:0] s;
      logic signed [17:0] p;
      s = 18'(score);
      p = 18'(ply);
      if (s > MATE_HI) begin
         s = s - p;
      end else if (s < MATE_LO) begin
         s = s + p;
      end
      return sat_score(s);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/srt_ctrl.sv =====
// Sequencing state machine for the search result table.
`default_nettype none

module srt_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  srt_pkg::status_type status,
   output srt_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_SWEEP = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_EVAL  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       pend_ff, pend_in;   // sweep was started by a clear request

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.req_clear) begin
                  state_in = ST_SWEEP;
                  pend_in  = 1'b1;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_SWEEP: begin
            cmd.sweep_wr = 1'b1;
            if (status.sweep_last) begin
               state_in = pend_ff ? ST_DONE : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/srt_datapath.sv =====
// Table memory, lookup, replacement, score adjustment and result register.
`default_nettype none

module srt_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  srt_pkg::req_type     req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output srt_pkg::rsp_type     rsp_payload,
   input  srt_pkg::cmd_type     cmd,
   output srt_pkg::status_type  status
);

   srt_pkg::entry_type mem_q [srt_pkg::TABLE_SIZE];

   srt_pkg::req_type   req_ff;
   srt_pkg::entry_type rd_ff;
   logic [srt_pkg::INDEX_BITS-1:0] sweep_ff;
   logic [srt_pkg::INDEX_BITS-1:0] idx;

   // evaluation stage
   logic               match_ff, usable_ff, has_move_ff, written_ff;
   logic signed [15:0] hs_ff;
   logic [1:0]         sbound_ff;
   logic [15:0]        move_ff;

   logic               match, usable, replace, do_store;
   logic [6:0]         ply_c;
   srt_pkg::entry_type wr_entry;
   logic [srt_pkg::INDEX_BITS-1:0] wr_addr;
   logic               wr_en;

   logic               rsp_valid_ff;
   srt_pkg::rsp_type   rsp_ff, rsp_in;
   logic signed [15:0] na, nb;
   logic               cut;

   assign idx   = req_ff.hash[srt_pkg::INDEX_BITS-1:0];
   assign ply_c = srt_pkg::clamp_ply(req_ff.ply);

   assign status.req_clear  = (req_payload.kind == srt_pkg::KIND_CLEAR);
   assign status.sweep_last = &sweep_ff;
   assign status.out_busy   = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   // lookup and replacement decision on the read entry
   always_comb begin
      match    = (req_ff.kind == srt_pkg::KIND_PROBE) && rd_ff.valid &&
                 (rd_ff.key == req_ff.hash);
      usable   = match && (rd_ff.depth >= req_ff.depth);
      replace  = !rd_ff.valid || (rd_ff.key != req_ff.hash) ||
                 (req_ff.depth >= rd_ff.depth);
      do_store = cmd.eval && (req_ff.kind == srt_pkg::KIND_STORE) && replace;

      wr_entry.valid    = 1'b1;
      wr_entry.key      = req_ff.hash;
      wr_entry.depth    = req_ff.depth;
      wr_entry.score    = srt_pkg::to_table(req_ff.score, ply_c);
      wr_entry.bound    = req_ff.bound_type;
      wr_entry.has_move = req_ff.move_present;
      wr_entry.move     = req_ff.move_present ? req_ff.move_word : 16'h0000;
      if (cmd.sweep_wr) begin
         wr_entry = '0;
      end
      wr_addr = cmd.sweep_wr ? sweep_ff : idx;
      wr_en   = cmd.sweep_wr || do_store;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_entry;
      end
      if (cmd.read) begin
         rd_ff <= mem_q[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_wr) begin
         sweep_ff <= sweep_ff + {{(srt_pkg::INDEX_BITS-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         match_ff    <= match;
         usable_ff   <= usable;
         has_move_ff <= match && rd_ff.has_move;
         move_ff     <= rd_ff.move;
         hs_ff       <= srt_pkg::from_table(rd_ff.score, ply_c);
         sbound_ff   <= rd_ff.bound;
         written_ff  <= (req_ff.kind == srt_pkg::KIND_STORE) && replace;
      end
   end

   // window tightening and result assembly
   always_comb begin
      na  = req_ff.alpha;
      nb  = req_ff.beta;
      cut = 1'b0;
      if (usable_ff) begin
         if (sbound_ff == srt_pkg::BOUND_EXACT) begin
            cut = 1'b1;
         end else begin
            if (sbound_ff == srt_pkg::BOUND_LOWER && hs_ff > na) begin
               na = hs_ff;
            end
            if (sbound_ff == srt_pkg::BOUND_UPPER && hs_ff < nb) begin
               nb = hs_ff;
            end
            cut = (na >= nb);
         end
      end
      rsp_in = '0;
      if (req_ff.kind == srt_pkg::KIND_PROBE) begin
         rsp_in.key_match  = match_ff;
         rsp_in.usable_hit = usable_ff;
         rsp_in.cutoff     = cut;
         rsp_in.hit_score  = usable_ff ? hs_ff : 16'sd0;
         rsp_in.new_alpha  = na;
         rsp_in.new_beta   = nb;
         rsp_in.move_found = has_move_ff;
         rsp_in.found_move = has_move_ff ? move_ff : 16'h0000;
      end else if (req_ff.kind == srt_pkg::KIND_STORE) begin
         rsp_in.written = written_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/search_result_table_core.sv =====
// Top level of the search result table: controller plus datapath.
// Probe/store: captured, then read, evaluated and finished (response loaded once the
//   output is free); one request at a time, as read, evaluate and finish share one port.
// Clear: sweeps all 2^INDEX_BITS entries, then responds; no request taken.
// Reset: synchronous, active high; starts the same sweep with req_stall high.
`default_nettype none

module search_result_table_core (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  srt_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output srt_pkg::rsp_type  rsp_payload
);

   // Command and status between the sequencer and the datapath.
   srt_pkg::cmd_type    cmd;
   srt_pkg::status_type status;

   // Sequencer: idle / read / evaluate / finish, plus the table sweep.
   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: table memory, replacement rule, mate scoring, window update,
   // and the response register that lets a finished response wait on rsp_stall.
   srt_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire

// ===== rtl/srt_checker.sv =====
// Port-level checks on the search result table, bound to the top level.
`default_nettype none

module srt_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_stall,
   input srt_pkg::req_type req_payload,
   input wire              rsp_valid,
   input wire              rsp_stall,
   input srt_pkg::rsp_type rsp_payload
);

   // One request at a time: after taking a request the input is stalled.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("stalled request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_unusable_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.usable_hit |->
         !rsp_payload.cutoff && rsp_payload.hit_score == 16'sd0)
      else $error("cutoff or score without usable hit");

   a_move_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.key_match |->
         !rsp_payload.move_found && !rsp_payload.usable_hit)
      else $error("move or hit reported without key match");

endmodule

bind search_result_table_core srt_checker u_srt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== tb/sv/srt_response_checker.sv =====
// Response checker for the search result table: mirrors the table and compares every response.
`timescale 1ns / 1ps

module srt_response_checker (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   input  wire                       req_stall,
   input  srt_pkg::req_type          req_payload,
   input  wire                       rsp_valid,
   input  wire                       rsp_stall,
   input  srt_pkg::rsp_type          rsp_payload,
   output int                        mismatches,
   output int                        awaited
);

   typedef struct {
      bit          used;
      logic [63:0] key;
      int          depth;
      int          score;
      logic [1:0]  bound;
      bit          has_move;
      logic [15:0] move;
   } slot_type;

   slot_type         slots [srt_pkg::TABLE_SIZE];
   srt_pkg::rsp_type table_answers [$];

   initial begin
      mismatches = 0;
      awaited    = 0;
   end

   function automatic int clip_score(int s);
      if (s > srt_pkg::SCORE_MAX) return srt_pkg::SCORE_MAX;
      if (s < -srt_pkg::SCORE_MAX) return -srt_pkg::SCORE_MAX;
      return s;
   endfunction

   // Applies one request to the mirrored table and returns the response it should give.
   function automatic srt_pkg::rsp_type table_access(srt_pkg::req_type r);
      srt_pkg::rsp_type ans;
      int      idx;
      int      ply;
      int      req_depth;
      int      s;
      int      lo;
      int      hi;
      bit      hit;
      ans       = '0;
      idx       = int'(r.hash[srt_pkg::INDEX_BITS-1:0]);
      ply       = int'(r.ply);
      req_depth = r.depth;
      if (ply > srt_pkg::PLY_LIMIT - 1) ply = srt_pkg::PLY_LIMIT - 1;
      case (r.kind)
         srt_pkg::KIND_PROBE: begin
            hit = slots[idx].used && slots[idx].key == r.hash;
            lo  = r.alpha;
            hi  = r.beta;
            s   = 0;
            if (hit && slots[idx].depth >= req_depth) begin
               s = slots[idx].score;
               if (s > srt_pkg::MATE_RANGE) s -= ply;
               else if (s < -srt_pkg::MATE_RANGE) s += ply;
               s = clip_score(s);
               ans.usable_hit = 1'b1;
               if (slots[idx].bound == srt_pkg::BOUND_EXACT) begin
                  ans.cutoff = 1'b1;
               end else begin
                  if (slots[idx].bound == srt_pkg::BOUND_LOWER && s > lo) lo = s;
                  if (slots[idx].bound == srt_pkg::BOUND_UPPER && s < hi) hi = s;
                  ans.cutoff = (lo >= hi);
               end
            end
            ans.key_match  = hit;
            ans.hit_score  = 16'(s);
            ans.new_alpha  = 16'(lo);
            ans.new_beta   = 16'(hi);
            ans.move_found = hit && slots[idx].has_move;
            ans.found_move = ans.move_found ? slots[idx].move : 16'h0;
         end
         srt_pkg::KIND_STORE: begin
            if (!slots[idx].used || slots[idx].key != r.hash ||
                req_depth >= slots[idx].depth) begin
               s = r.score;
               if (s > srt_pkg::MATE_RANGE) s += ply;
               else if (s < -srt_pkg::MATE_RANGE) s -= ply;
               slots[idx].used     = 1'b1;
               slots[idx].key      = r.hash;
               slots[idx].depth    = req_depth;
               slots[idx].score    = clip_score(s);
               slots[idx].bound    = r.bound_type;
               slots[idx].has_move = r.move_present;
               slots[idx].move     = r.move_present ? r.move_word : 16'h0;
               ans.written         = 1'b1;
            end
         end
         srt_pkg::KIND_CLEAR: begin
            foreach (slots[i]) slots[i].used = 1'b0;
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic void compare_field(string field, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      srt_pkg::rsp_type got;
      srt_pkg::rsp_type want;
      if (reset) begin
         foreach (slots[i]) slots[i].used = 1'b0;
         table_answers.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (table_answers.size() == 0) begin
               $display("%0t: response with nothing expected, got %p", $time, got);
               mismatches++;
            end else begin
               want = table_answers.pop_front();
               compare_field("key_match", want.key_match, got.key_match);
               compare_field("usable_hit", want.usable_hit, got.usable_hit);
               compare_field("cutoff", want.cutoff, got.cutoff);
               compare_field("hit_score", want.hit_score, got.hit_score);
               compare_field("new_alpha", want.new_alpha, got.new_alpha);
               compare_field("new_beta", want.new_beta, got.new_beta);
               compare_field("move_found", want.move_found, got.move_found);
               compare_field("found_move", want.found_move, got.found_move);
               compare_field("written", want.written, got.written);
            end
         end
         if (req_valid && !req_stall) table_answers.push_back(table_access(req_payload));
      end
      awaited = table_answers.size();
   end

endmodule

// ===== tb/sv/tb_search_result_table_core.sv =====
// Testbench top for the search result table: request stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_search_result_table_core;

   // Codes the block must tolerate but never names itself.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] BOUND_SPARE = 2'd3;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   srt_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   srt_pkg::rsp_type rsp_payload;
   int               mismatches;
   int               awaited;

   // Idling odds in percent per cycle; hold_left counts down a long receiver hold-off.
   int          sender_idle_pct   = 23;
   int          receiver_idle_pct = 83;
   int          hold_left         = 0;

   // Sixteen keys on four table slots, so stores and probes keep colliding.
   logic [63:0] key_pool [16];

   search_result_table_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   srt_response_checker answer_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .mismatches  (mismatches),
      .awaited     (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reset sweep plus ~1750 requests and a dozen clears stay far below this.
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   // Receiver: stall decided at each falling edge; a pending hold-off wins over the odds.
   initial begin
      rsp_stall = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < receiver_idle_pct);
         end
      end
   end

   function automatic srt_pkg::req_type make_req(logic [1:0] kind, logic [63:0] hash,
                                                 int depth, int ply, int score, int alpha,
                                                 int beta, logic [1:0] bound,
                                                 logic present, logic [15:0] move);
      srt_pkg::req_type r;
      r.kind         = kind;
      r.hash         = hash;
      r.depth        = 8'(depth);
      r.ply          = 7'(ply);
      r.score        = 16'(score);
      r.alpha        = 16'(alpha);
      r.beta         = 16'(beta);
      r.bound_type   = bound;
      r.move_present = present;
      r.move_word    = move;
      return r;
   endfunction

   // Scores: plain range, both mate ranges (with -32768), or any 16-bit pattern.
   function automatic logic [15:0] pick_score();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = $urandom_range(0, 65535);
         3, 4:    v = $urandom_range(31000, 32767);
         5, 6:    v = -int'($urandom_range(31000, 32768));
         default: v = int'($urandom_range(0, 4000)) - 2000;
      endcase
      return 16'(v);
   endfunction

   function automatic srt_pkg::req_type random_request();
      srt_pkg::req_type r;
      int               pick;
      pick = $urandom_range(0, 999);
      if (pick < 5) r.kind = srt_pkg::KIND_CLEAR;    // each clear costs a full sweep
      else if (pick < 25) r.kind = KIND_UNUSED;
      else if (pick < 510) r.kind = srt_pkg::KIND_PROBE;
      else r.kind = srt_pkg::KIND_STORE;
      r.hash = ($urandom_range(0, 6) == 0) ? {$urandom, $urandom}
                                           : key_pool[$urandom_range(0, 15)];
      // Narrow depths make the replacement and usable-hit compares go both ways.
      r.depth        = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(0, 16) - 4);
      r.ply          = 7'($urandom);
      r.score        = pick_score();
      r.alpha        = pick_score();
      r.beta         = pick_score();
      r.bound_type   = 2'($urandom_range(0, 3));
      r.move_present = 1'($urandom);
      r.move_word    = 16'($urandom);
      return r;
   endfunction

   // Offers one request from a falling edge and returns at the falling edge after acceptance.
   // Valid stays high on return, so back-to-back requests drop it only when the sender idles.
   task automatic send_request(srt_pkg::req_type r);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   initial begin
      int          slot_sel;
      logic [63:0] ones;
      req_valid   = 1'b0;
      req_payload = '0;
      reset       = 1'b1;
      ones        = '1;
      slot_sel    = 0;
      for (int i = 0; i < 16; i++) begin
         if (i % 4 == 0) slot_sel = $urandom_range(0, srt_pkg::TABLE_SIZE - 1);
         key_pool[i] = {$urandom, $urandom};
         key_pool[i][srt_pkg::INDEX_BITS-1:0] = slot_sel[srt_pkg::INDEX_BITS-1:0];
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty slot, replacement by depth and by key, mate adjustment both ways,
      // saturation, window tightening and closing, bound code three, unknown kind, clear.
      send_request(make_req(srt_pkg::KIND_PROBE, key_pool[0], 0, 0, 0, 0, 0,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_STORE, key_pool[0], 5, 0, 100, 0, 0,
                            srt_pkg::BOUND_EXACT, 1'b1, 16'h1234));
      send_request(make_req(srt_pkg::KIND_PROBE, key_pool[0], 5, 0, 0, -50, 50,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_PROBE, key_pool[0], 6, 0, 0, -50, 50,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_STORE, key_pool[0], 4, 0, 7, 0, 0,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_STORE, key_pool[0], 5, 10, 31500, 0, 0,
                            srt_pkg::BOUND_LOWER, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_PROBE, key_pool[0], -128, 4, 0, 0, 32767,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_PROBE, key_pool[0], 5, 127, 0, -32768, -32768,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_STORE, key_pool[1], -16, 127, -32768, 0, 0,
                            srt_pkg::BOUND_UPPER, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_PROBE, key_pool[1], -16, 0, 0, -32767, 32767,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_PROBE, key_pool[1], -16, 127, 0, -32768, 0,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_STORE, key_pool[2], 127, 127, 32767, 0, 0,
                            BOUND_SPARE, 1'b1, 16'hFFFF));
      send_request(make_req(srt_pkg::KIND_PROBE, key_pool[2], 127, 127, 0, 32767, -32767,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_PROBE, key_pool[2], 127, 0, 0, -32768, 32767,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_STORE, ones, -128, 1, -31001, 0, 0,
                            srt_pkg::BOUND_LOWER, 1'b1, 16'h0000));
      send_request(make_req(srt_pkg::KIND_PROBE, ones, -128, 127, 0, 32767, 32767,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_STORE, '0, 0, 127, 31000, 0, 0,
                            srt_pkg::BOUND_UPPER, 1'b1, 16'h8001));
      send_request(make_req(srt_pkg::KIND_PROBE, '0, 0, 127, 0, -100, 32767,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(KIND_UNUSED, ones, -1, 127, -1, -1, -1,
                            BOUND_SPARE, 1'b1, 16'hFFFF));
      send_request(make_req(srt_pkg::KIND_CLEAR, key_pool[2], 0, 0, 0, 0, 0,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_PROBE, key_pool[2], -128, 0, 0, 0, 0,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));
      send_request(make_req(srt_pkg::KIND_PROBE, '0, -128, 0, 0, 0, 0,
                            srt_pkg::BOUND_EXACT, 1'b0, 16'h0000));

      // Random: sender fast / receiver slow, then swapped, then flat out with a long
      // receiver hold-off so the block backs up into req_stall.
      for (int n = 0; n < 1730; n++) begin
         if (n == 600) begin
            sender_idle_pct   = 83;
            receiver_idle_pct = 23;
         end
         if (n == 1200) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
            hold_left         = 300;
         end
         send_request(random_request());
      end
      req_valid = 1'b0;

      // Drain, then wait on to catch any stray response.
      while (awaited != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/srt_pkg.sv
rtl/srt_ctrl.sv
rtl/srt_datapath.sv
rtl/search_result_table_core.sv
rtl/srt_checker.sv
tb/sv/srt_response_checker.sv
tb/sv/tb_search_result_table_core.sv
